[design/sem_pkg.sv]
// ----------------------------------------------------------------------------
// sem_pkg
// shared types, constants and kernel coefficients for the sobel edge core
// ----------------------------------------------------------------------------
package sem_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int DIM_W   = $clog2(((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) + 1);
  localparam int CNT_W   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int HIST_AW = $clog2(2 * MAX_WIDTH + 4);
  localparam int HIST_DEPTH = 1 << HIST_AW;
  localparam int PIX_W   = 24;
  localparam int TAP_W   = 4;
  localparam int TAPS    = 9;

  localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(480);

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  typedef struct packed {
    logic             store;
    logic             clear_acc;
    logic             issue;
    logic             acc;
    logic [TAP_W-1:0] tap;
    logic             sq_x;
    logic             sq_y;
    logic             root;
    logic [2:0]       bit_idx;
    logic             round;
    logic [1:0]       ch;
    logic             load;
  } sem_cmd_t;

  typedef struct packed {
    logic full;
    logic pend;
    logic emit_pix;
    logic out_busy;
  } sem_stat_t;

  function automatic logic signed [2:0] coef_x(input logic [TAP_W-1:0] k);
    logic signed [2:0] c;
    case (k)
      4'd0, 4'd6: c = -3'sd1;
      4'd2, 4'd8: c = 3'sd1;
      4'd3:       c = -3'sd2;
      4'd5:       c = 3'sd2;
      default:    c = 3'sd0;
    endcase
    return c;
  endfunction

  function automatic logic signed [2:0] coef_y(input logic [TAP_W-1:0] k);
    logic signed [2:0] c;
    case (k)
      4'd0, 4'd2: c = -3'sd1;
      4'd1:       c = -3'sd2;
      4'd6, 4'd8: c = 3'sd1;
      4'd7:       c = 3'sd2;
      default:    c = 3'sd0;
    endcase
    return c;
  endfunction

endpackage

[design/sem_ram.sv]
// ----------------------------------------------------------------------------
// sem_ram
// simple dual port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module sem_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/sem_datapath.sv]
// ----------------------------------------------------------------------------
// sem_datapath
// frame counters, pixel history, kernel accumulators, root unit, output reg
// ----------------------------------------------------------------------------
module sem_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  sem_pkg::sem_cmd_t           cmd,
  output sem_pkg::sem_stat_t          stat,
  input  logic                        cfg_we,
  input  logic                        cfg_addr,
  input  logic [sem_pkg::DIM_W-1:0]   cfg_data,
  input  logic [sem_pkg::PIX_W-1:0]   pix_in,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [sem_pkg::PIX_W-1:0]   m_tdata,
  output logic                        m_tlast
);

  logic [sem_pkg::DIM_W-1:0]   w_r, h_r, row, col, cfg_val, cfg_max;
  logic [sem_pkg::CNT_W-1:0]   items_seen, q, total, w_p1;
  logic [2*sem_pkg::DIM_W-1:0] area;
  logic                        last;
  logic                        col_lo, col_hi, row_lo, row_hi;
  logic [sem_pkg::HIST_AW-1:0] raddr, q_a, w_a, one_a;
  logic                        tap_ok, acc_ok;
  logic [sem_pkg::TAP_W-1:0]   acc_tap;
  logic [sem_pkg::PIX_W-1:0]   rdata;
  logic signed [10:0]          gx [3];
  logic signed [10:0]          gy [3];
  logic [20:0]                 s_r;
  logic [7:0]                  r_r, trial;
  logic [7:0]                  mag [3];
  logic signed [10:0]          gx_ch, gy_ch;
  logic [15:0]                 trial_sq;
  logic [16:0]                 r_bound;

  always_comb begin
    if (cfg_addr == sem_pkg::REG_HEIGHT) begin
      cfg_max = sem_pkg::DIM_W'(sem_pkg::MAX_HEIGHT);
    end else begin
      cfg_max = sem_pkg::DIM_W'(sem_pkg::MAX_WIDTH);
    end
    if (cfg_data == '0) begin
      cfg_val = sem_pkg::DIM_W'(1);
    end else if (cfg_data > cfg_max) begin
      cfg_val = cfg_max;
    end else begin
      cfg_val = cfg_data;
    end
  end

  assign area  = w_r * h_r;
  assign total = area[sem_pkg::CNT_W-1:0];
  assign w_p1  = sem_pkg::CNT_W'(w_r) + sem_pkg::CNT_W'(1);
  assign last  = (q == total - sem_pkg::CNT_W'(1));

  assign stat.full     = (items_seen >= total);
  assign stat.pend     = (q < total);
  assign stat.emit_pix = (items_seen >= w_p1);
  assign stat.out_busy = m_tvalid && !m_tready;

  // neighbour address and frame border check
  assign col_lo = (col != '0);
  assign row_lo = (row != '0);
  assign col_hi = ((col + sem_pkg::DIM_W'(1)) < w_r);
  assign row_hi = ((row + sem_pkg::DIM_W'(1)) < h_r);
  assign q_a    = q[sem_pkg::HIST_AW-1:0];
  assign w_a    = sem_pkg::HIST_AW'(w_r);
  assign one_a  = sem_pkg::HIST_AW'(1);

  always_comb begin
    case (cmd.tap)
      4'd0:    begin raddr = q_a - w_a - one_a; tap_ok = row_lo && col_lo; end
      4'd1:    begin raddr = q_a - w_a;         tap_ok = row_lo;           end
      4'd2:    begin raddr = q_a - w_a + one_a; tap_ok = row_lo && col_hi; end
      4'd3:    begin raddr = q_a - one_a;       tap_ok = col_lo;           end
      4'd4:    begin raddr = q_a;               tap_ok = 1'b1;             end
      4'd5:    begin raddr = q_a + one_a;       tap_ok = col_hi;           end
      4'd6:    begin raddr = q_a + w_a - one_a; tap_ok = row_hi && col_lo; end
      4'd7:    begin raddr = q_a + w_a;         tap_ok = row_hi;           end
      4'd8:    begin raddr = q_a + w_a + one_a; tap_ok = row_hi && col_hi; end
      default: begin raddr = q_a;               tap_ok = 1'b0;             end
    endcase
  end

  sem_ram #(
    .WIDTH(sem_pkg::PIX_W),
    .DEPTH(sem_pkg::HIST_DEPTH)
  ) u_hist (
    .clk  (clk),
    .we   (cmd.store),
    .waddr(items_seen[sem_pkg::HIST_AW-1:0]),
    .wdata(pix_in),
    .raddr(raddr),
    .rdata(rdata)
  );

  // counters and config
  always_ff @(posedge clk) begin
    if (rst) begin
      w_r        <= sem_pkg::WIDTH_RST;
      h_r        <= sem_pkg::HEIGHT_RST;
      items_seen <= '0;
      q          <= '0;
      row        <= '0;
      col        <= '0;
      m_tvalid   <= 1'b0;
      acc_ok     <= 1'b0;
    end else begin
      acc_ok <= cmd.issue && tap_ok;
      if (cfg_we) begin
        if (cfg_addr == sem_pkg::REG_WIDTH) begin
          w_r <= cfg_val;
        end else begin
          h_r <= cfg_val;
        end
        items_seen <= '0;
        q          <= '0;
        row        <= '0;
        col        <= '0;
      end else if (cmd.store) begin
        items_seen <= items_seen + sem_pkg::CNT_W'(1);
      end else if (cmd.load) begin
        if (last) begin
          items_seen <= '0;
          q          <= '0;
          row        <= '0;
          col        <= '0;
        end else begin
          q <= q + sem_pkg::CNT_W'(1);
          if (col_hi) begin
            col <= col + sem_pkg::DIM_W'(1);
          end else begin
            col <= '0;
            row <= row + sem_pkg::DIM_W'(1);
          end
        end
      end
      if (cmd.load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // kernel accumulation and root search
  assign gx_ch    = gx[cmd.ch];
  assign gy_ch    = gy[cmd.ch];
  assign trial    = r_r | (8'd1 << cmd.bit_idx);
  assign trial_sq = trial * trial;
  assign r_bound  = 17'(r_r * r_r) + 17'(r_r);

  always_ff @(posedge clk) begin
    logic signed [11:0] px, py;
    acc_tap <= cmd.tap;
    if (cmd.clear_acc) begin
      for (int c = 0; c < 3; c++) begin
        gx[c] <= '0;
        gy[c] <= '0;
      end
    end else if (cmd.acc && acc_ok) begin
      for (int c = 0; c < 3; c++) begin
        px = $signed({1'b0, rdata[8*c +: 8]}) * sem_pkg::coef_x(acc_tap);
        py = $signed({1'b0, rdata[8*c +: 8]}) * sem_pkg::coef_y(acc_tap);
        gx[c] <= gx[c] + px[10:0];
        gy[c] <= gy[c] + py[10:0];
      end
    end
    if (cmd.sq_x) begin
      s_r <= 21'(gx_ch * gx_ch);
    end else if (cmd.sq_y) begin
      s_r <= s_r + 21'(gy_ch * gy_ch);
    end
    if (cmd.sq_y) begin
      r_r <= '0;
    end else if (cmd.root && (21'(trial_sq) <= s_r)) begin
      r_r <= trial;
    end
    if (cmd.round) begin
      if (s_r > 21'd65280) begin
        mag[cmd.ch] <= 8'd255;
      end else if (s_r > 21'(r_bound)) begin
        mag[cmd.ch] <= r_r + 8'd1;
      end else begin
        mag[cmd.ch] <= r_r;
      end
    end
    if (cmd.load) begin
      m_tdata <= {mag[2], mag[1], mag[0]};
      m_tlast <= last;
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (!m_tvalid || m_tready))
    else $error("result loaded over a pending transaction");
  a_out_behind_in: assert property (@(posedge clk) disable iff (rst)
    q <= items_seen)
    else $error("result position ahead of input count");
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    (col < w_r) && (row < h_r))
    else $error("result position outside frame");
`endif

endmodule

[design/sem_ctrl.sv]
// ----------------------------------------------------------------------------
// sem_ctrl
// sequencer: stores pixels, fetches the window, runs the root per channel
// ----------------------------------------------------------------------------
module sem_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic                s_tuser,
  output logic                s_tready,
  input  sem_pkg::sem_stat_t  stat,
  output sem_pkg::sem_cmd_t   cmd
);

  typedef enum logic [2:0] {
    IDLE, FETCH, SQX, SQY, ROOT, ROUND, LOAD
  } state_t;

  state_t                    state;
  logic [sem_pkg::TAP_W-1:0] k;
  logic [2:0]                bit_idx;
  logic [1:0]                ch;
  logic                      go;

  assign s_tready = (state == IDLE);

  always_comb begin
    if (s_tuser == sem_pkg::ACT_PIXEL) begin
      go = !stat.full && stat.emit_pix;
    end else begin
      go = stat.full && stat.pend;
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.tap       = k;
    cmd.bit_idx   = bit_idx;
    cmd.ch        = ch;
    cmd.store     = (state == IDLE) && s_tvalid && (s_tuser == sem_pkg::ACT_PIXEL)
                    && !stat.full;
    cmd.clear_acc = (state == IDLE) && s_tvalid && go;
    cmd.issue     = (state == FETCH) && (k < sem_pkg::TAP_W'(sem_pkg::TAPS));
    cmd.acc       = (state == FETCH) && (k != '0);
    cmd.sq_x      = (state == SQX);
    cmd.sq_y      = (state == SQY);
    cmd.root      = (state == ROOT);
    cmd.round     = (state == ROUND);
    cmd.load      = (state == LOAD) && !stat.out_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= IDLE;
      k       <= '0;
      bit_idx <= '0;
      ch      <= '0;
    end else begin
      case (state)
        IDLE: begin
          k <= '0;
          if (s_tvalid && go) begin
            state <= FETCH;
          end
        end
        FETCH: begin
          k <= k + sem_pkg::TAP_W'(1);
          if (k == sem_pkg::TAP_W'(sem_pkg::TAPS)) begin
            ch    <= '0;
            state <= SQX;
          end
        end
        SQX: begin
          state <= SQY;
        end
        SQY: begin
          bit_idx <= 3'd7;
          state   <= ROOT;
        end
        ROOT: begin
          bit_idx <= bit_idx - 3'd1;
          if (bit_idx == '0) begin
            state <= ROUND;
          end
        end
        ROUND: begin
          if (ch == 2'd2) begin
            state <= LOAD;
          end else begin
            ch    <= ch + 2'd1;
            state <= SQX;
          end
        end
        LOAD: begin
          if (!stat.out_busy) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_tap_range: assert property (@(posedge clk) disable iff (rst)
    (state == FETCH) |-> (k <= sem_pkg::TAP_W'(sem_pkg::TAPS)))
    else $error("window fetch ran past last tap");
  a_store_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.store |=> (state == IDLE || state == FETCH))
    else $error("pixel stored outside idle");
  a_ch_range: assert property (@(posedge clk) disable iff (rst)
    (state == ROUND) |-> (ch <= 2'd2))
    else $error("channel index out of range");
`endif

endmodule

[design/sobel_edge_magnitude_core.sv]
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_core
// 3x3 sobel edge magnitude of rgb pixel streams, one result per channel
// ----------------------------------------------------------------------------
// Pixels enter in raster order; results leave in raster order, frame_width+1
// items behind, and flush transactions after the last pixel drain the rest,
// the final result carrying tlast. An item that yields no result leaves the
// core ready for the next item. An item that yields a result first fetches
// the nine window pixels through the single read port of the history ram,
// then per channel one square, one square-sum, eight root steps and one
// rounding step on a shared root unit, then loads the output register, which
// waits as long as the previous result is still held by a low m_tready. The
// history ram needs no clearing after reset.
module sobel_edge_magnitude_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // blue_in, green_in, red_in
  input  logic        s_tuser,   // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // blue_out, green_out, red_out
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [10:0] cfg_data
);

  sem_pkg::sem_cmd_t  cmd;
  sem_pkg::sem_stat_t stat;

  sem_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tuser (s_tuser),
    .s_tready(s_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  sem_datapath u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .stat    (stat),
    .cfg_we  (cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_data(cfg_data),
    .pix_in  (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

endmodule
